// File: rtl/mono_bitmap_rotate_to_printer_columns_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the monochrome bitmap rotator
// Shared immediate-implication and next-cycle-implication checks.
// ---------------------------------------------------------------------------
`ifndef MONO_BITMAP_ROTATE_TO_PRINTER_COLUMNS_TOP_DEFINES_SVH
`define MONO_BITMAP_ROTATE_TO_PRINTER_COLUMNS_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MBR_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define MBR_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mbr_pkg.sv
// ---------------------------------------------------------------------------
// mbr_pkg
// Constants, codes and shared types of the bitmap rotator.
// ---------------------------------------------------------------------------
package mbr_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int STRIDE_ROUND = 31;
  localparam int MAX_STRIDE   = ((MAX_WIDTH + STRIDE_ROUND) / 32) * 4;
  localparam int STORE_DEPTH  = MAX_STRIDE * MAX_HEIGHT;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  localparam int DIM_W  = 9;
  localparam int DATA_W = 8;
  localparam int CFG_AW = 2;

  localparam logic [CFG_AW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_HEIGHT = 2'd1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ADDR  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_PUSH  = 5'b10000
  } mbr_state_t;

  typedef struct packed {
    logic       start;
    logic       err;
    logic       last;
    logic       shift;
    logic       push;
    logic [2:0] sel;
  } mbr_ctl_t;

endpackage

// File: rtl/mono_bitmap_rotate_to_printer_columns_top.sv
// ---------------------------------------------------------------------------
// mono_bitmap_rotate_to_printer_columns_top
// Loads a 1-bit bitmap and returns it byte by byte in printer column order.
//
//  channel  dir  tdata (low bit up)   tuser            tlast
//  in_      in   data_byte[7:0]       action           -
//  out_     out  rotated_byte[7:0]    dims_error       last_byte
//  cfg_     in   cfg_wdata: 0 width, 1 height (9 bits each), no read-back
//
//  Load: one store write. Read: address multiply, eight single-bit passes
//  over the store read port, one drain, one push; with bad dims only the push.
//  Synchronous active-low reset; width and height come up as 8.
//  A finished byte sits in the output register while the next request is
//  taken; a read waits in its push step while that register is full.
// ---------------------------------------------------------------------------
`include "mono_bitmap_rotate_to_printer_columns_top_defines.svh"

module mono_bitmap_rotate_to_printer_columns_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // data_byte[7:0]
  input  logic                        in_tuser,   // action
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // rotated_byte[7:0]
  output logic                        out_tlast,
  output logic                        out_tuser,  // dims_error
  input  logic                        cfg_we,
  input  logic [mbr_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [mbr_pkg::DIM_W-1:0]   cfg_wdata
);

  mbr_pkg::mbr_ctl_t          ctl;
  logic                       out_free;
  logic                       st_we, st_re;
  logic [mbr_pkg::ADDR_W-1:0] st_waddr, st_raddr;
  logic [mbr_pkg::DATA_W-1:0] st_wdata, st_rdata;

  mbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_free  (out_free),
    .ctl       (ctl),
    .st_we     (st_we),
    .st_waddr  (st_waddr),
    .st_wdata  (st_wdata),
    .st_re     (st_re),
    .st_raddr  (st_raddr)
  );

  mbr_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  mbr_col_shift u_col_shift (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rd_data    (st_rdata),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `MBR_AST_IMP(a_push_slot_free, ctl.push, (!out_tvalid || out_tready), "push into full output")
  `MBR_AST_IMP(a_no_req_in_gather, (st_re || ctl.shift || ctl.push), !in_tready, "request taken while busy")
  `MBR_AST_NXT(a_load_no_result, (in_tvalid && in_tready && (in_tuser == mbr_pkg::ACT_LOAD) && !out_tvalid), !out_tvalid, "load made a result")

endmodule

// File: rtl/mbr_store.sv
// ---------------------------------------------------------------------------
// mbr_store
// Image byte store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module mbr_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [mbr_pkg::ADDR_W-1:0]  waddr,
  input  logic [mbr_pkg::DATA_W-1:0]  wdata,
  input  logic                        re,
  input  logic [mbr_pkg::ADDR_W-1:0]  raddr,
  output logic [mbr_pkg::DATA_W-1:0]  rdata
);

  logic [mbr_pkg::DATA_W-1:0] mem [mbr_pkg::STORE_DEPTH];
  logic [mbr_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/mbr_col_shift.sv
// ---------------------------------------------------------------------------
// mbr_col_shift
// Gathers one pixel per cycle into the column byte and holds the result
// register toward the output stream.
// ---------------------------------------------------------------------------
module mbr_col_shift (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mbr_pkg::mbr_ctl_t           ctl,
  input  logic [mbr_pkg::DATA_W-1:0]  rd_data,
  output logic                        out_free,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mbr_pkg::DATA_W-1:0]  out_tdata,
  output logic                        out_tlast,
  output logic                        out_tuser
);

  logic [mbr_pkg::DATA_W-1:0] byte_r;
  logic                       last_r;
  logic                       err_r;
  logic                       valid_r;
  logic [mbr_pkg::DATA_W-1:0] odata_r;
  logic                       olast_r;
  logic                       oerr_r;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      byte_r <= '0;
      last_r <= ctl.last;
      err_r  <= ctl.err;
    end else if (ctl.shift) begin
      byte_r <= {byte_r[mbr_pkg::DATA_W-2:0], rd_data[ctl.sel]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.push) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      odata_r <= byte_r;
      olast_r <= last_r;
      oerr_r  <= err_r;
    end
  end

  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = oerr_r;

endmodule

// File: rtl/mbr_ctrl.sv
// ---------------------------------------------------------------------------
// mbr_ctrl
// Dimension registers, load and read counters, and the bit-serial read
// sequencer that walks eight source rows for one column byte.
// ---------------------------------------------------------------------------
module mbr_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        in_tuser,
  input  logic [mbr_pkg::DATA_W-1:0]  in_tdata,
  input  logic                        cfg_we,
  input  logic [mbr_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [mbr_pkg::DIM_W-1:0]   cfg_wdata,
  input  logic                        out_free,
  output mbr_pkg::mbr_ctl_t           ctl,
  output logic                        st_we,
  output logic [mbr_pkg::ADDR_W-1:0]  st_waddr,
  output logic [mbr_pkg::DATA_W-1:0]  st_wdata,
  output logic                        st_re,
  output logic [mbr_pkg::ADDR_W-1:0]  st_raddr
);

  localparam int AW = mbr_pkg::ADDR_W;
  localparam int DW = mbr_pkg::DIM_W;

  mbr_pkg::mbr_state_t state_r, state_nxt;

  logic [DW-1:0] width_r, height_r;
  logic [AW-1:0] load_addr_r, load_addr_nxt;
  logic [7:0]    col_r, col_nxt;
  logic [4:0]    band_r, band_nxt;
  logic [7:0]    cur_x_r;
  logic [4:0]    cur_b_r;
  logic [AW-1:0] rd_addr_r;
  logic [2:0]    cnt_r;
  logic          rd_v_r;

  logic          dims_ok;
  logic [9:0]    w_sum;
  logic [6:0]    stride;
  logic [15:0]   lim_prod;
  logic [AW:0]   limit;
  logic [AW-1:0] la_base;
  logic [AW:0]   la_inc;
  logic          accept, acc_load, acc_read, cfg_hit;
  logic [5:0]    bands;
  logic          out_of_range;
  logic [7:0]    cx;
  logic [4:0]    cb;
  logic          is_last;
  logic [5:0]    band_inc;
  logic [8:0]    col_inc;
  logic [8:0]    row0;
  logic [13:0]   row_prod;

  assign dims_ok = (width_r != '0) && (height_r != '0) &&
                   (width_r[2:0] == 3'd0) && (height_r[2:0] == 3'd0) &&
                   (width_r <= DW'(mbr_pkg::MAX_WIDTH)) &&
                   (height_r <= DW'(mbr_pkg::MAX_HEIGHT));

  assign w_sum    = {1'b0, width_r} + 10'(mbr_pkg::STRIDE_ROUND);
  assign stride   = {w_sum[9:5], 2'b00};
  assign lim_prod = stride * height_r;
  assign limit    = dims_ok ? lim_prod[AW:0] : (AW+1)'(mbr_pkg::STORE_DEPTH);

  assign accept   = in_tvalid && in_tready;
  assign acc_load = accept && (in_tuser == mbr_pkg::ACT_LOAD);
  assign acc_read = accept && (in_tuser == mbr_pkg::ACT_READ);

  // load address with wrap at the image end
  always_comb begin
    la_base       = ({1'b0, load_addr_r} >= limit) ? '0 : load_addr_r;
    la_inc        = {1'b0, la_base} + 1'b1;
    load_addr_nxt = (la_inc >= limit) ? '0 : la_inc[AW-1:0];
  end

  // column / band walk
  always_comb begin
    bands        = height_r[8:3];
    out_of_range = ({1'b0, col_r} >= width_r) || ({1'b0, band_r} >= bands);
    cx           = out_of_range ? '0 : col_r;
    cb           = out_of_range ? '0 : band_r;
    is_last      = ({1'b0, cx} == (width_r - 9'd1)) && ({1'b0, cb} == (bands - 6'd1));
    band_inc     = {1'b0, cb} + 6'd1;
    col_inc      = {1'b0, cx} + 9'd1;
    if (band_inc < bands) begin
      band_nxt = band_inc[4:0];
      col_nxt  = cx;
    end else begin
      band_nxt = '0;
      col_nxt  = (col_inc < width_r) ? col_inc[7:0] : '0;
    end
  end

  assign row0     = height_r - 9'd1 - {1'b0, cur_b_r, 3'b000};
  assign row_prod = row0[7:0] * stride[5:0];

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we) begin
      unique case (cfg_addr)
        mbr_pkg::CFG_WIDTH:  cfg_hit = 1'b1;
        mbr_pkg::CFG_HEIGHT: cfg_hit = 1'b1;
        default:             cfg_hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mbr_pkg::ST_IDLE: begin
        if (acc_read) begin
          state_nxt = dims_ok ? mbr_pkg::ST_ADDR : mbr_pkg::ST_PUSH;
        end
      end
      mbr_pkg::ST_ADDR:  state_nxt = mbr_pkg::ST_READ;
      mbr_pkg::ST_READ: begin
        if (cnt_r == 3'd7) begin
          state_nxt = mbr_pkg::ST_DRAIN;
        end
      end
      mbr_pkg::ST_DRAIN: state_nxt = mbr_pkg::ST_PUSH;
      mbr_pkg::ST_PUSH: begin
        if (out_free) begin
          state_nxt = mbr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mbr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbr_pkg::ST_IDLE;
      width_r     <= DW'(8);
      height_r    <= DW'(8);
      load_addr_r <= '0;
      col_r       <= '0;
      band_r      <= '0;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == mbr_pkg::ST_READ);
      if (cfg_we && (cfg_addr == mbr_pkg::CFG_WIDTH)) begin
        width_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_addr == mbr_pkg::CFG_HEIGHT)) begin
        height_r <= cfg_wdata;
      end
      if (cfg_hit) begin
        load_addr_r <= '0;
        col_r       <= '0;
        band_r      <= '0;
      end else begin
        if (acc_load) begin
          load_addr_r <= load_addr_nxt;
        end
        if (acc_read && dims_ok) begin
          col_r  <= col_nxt;
          band_r <= band_nxt;
        end
      end
      if (state_r == mbr_pkg::ST_READ) begin
        cnt_r <= cnt_r + 3'd1;
      end else begin
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_read) begin
      cur_x_r <= cx;
      cur_b_r <= cb;
    end
    if (state_r == mbr_pkg::ST_ADDR) begin
      rd_addr_r <= row_prod[AW-1:0] + {{(AW-5){1'b0}}, cur_x_r[7:3]};
    end else if (state_r == mbr_pkg::ST_READ) begin
      rd_addr_r <= rd_addr_r - {{(AW-6){1'b0}}, stride[5:0]};
    end
  end

  assign in_tready = (state_r == mbr_pkg::ST_IDLE);

  assign st_we    = acc_load;
  assign st_waddr = la_base;
  assign st_wdata = ~in_tdata;
  assign st_re    = (state_r == mbr_pkg::ST_READ);
  assign st_raddr = rd_addr_r;

  assign ctl.start = acc_read;
  assign ctl.err   = !dims_ok;
  assign ctl.last  = dims_ok && is_last;
  assign ctl.shift = rd_v_r;
  assign ctl.push  = (state_r == mbr_pkg::ST_PUSH) && out_free;
  assign ctl.sel   = ~cur_x_r[2:0];

endmodule

// File: tb/mono_bitmap_rotate_to_printer_columns_top_tb.sv
// ----------------------------------------------------------------------------
// Bitmap rotator regression bench
// Streams load and read requests into the rotator and checks every returned
// column byte against a cycle-free predictor. A stimulus queue feeds a
// clocked driver with random gaps, and a clocked monitor stalls at random and
// once for a long stretch. Runs cover the reset size, small random images,
// the widest image, bad dimensions and writes to unused register indexes.
// ----------------------------------------------------------------------------
module mono_bitmap_rotate_to_printer_columns_top_tb;
  import mbr_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 16;
  localparam int HOLD_LEN     = 400;
  localparam int BIG_PHASE    = 2;

  localparam logic [CFG_AW-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_SPARE3 = 2'd3;

  typedef struct packed {
    logic       act;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic [7:0] rot;
    logic       last;
    logic       err;
  } col_byte_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;   // data_byte[7:0]
  logic              in_tuser = 1'b0; // action
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;       // rotated_byte[7:0]
  logic              out_tlast;
  logic              out_tuser;       // dims_error
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [DIM_W-1:0]  cfg_wdata = '0;

  mono_bitmap_rotate_to_printer_columns_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [7:0]        p_store [STORE_DEPTH];
  logic [ADDR_W-1:0] p_ld;
  logic [7:0]        p_col;
  logic [4:0]        p_band;
  logic [DIM_W-1:0]  p_w;
  logic [DIM_W-1:0]  p_h;

  // stimulus-side shadow, used to keep reads on written entries
  bit                g_written [STORE_DEPTH];
  logic [ADDR_W-1:0] g_ld;
  logic [DIM_W-1:0]  g_w;
  logic [DIM_W-1:0]  g_h;

  req_t        req_q [$];
  col_byte_t   column_bytes_q [$];
  req_t        drv_req;
  col_byte_t   want;
  int          in_gap = 0;
  int          out_gap = 0;
  int          out_hold = 0;
  int          hold_ask = 0;
  int          hold_seen = 0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  int unsigned n_cycles = 0;
  int unsigned n_fail = 0;
  int unsigned n_loads = 0;
  int unsigned n_reads = 0;
  int unsigned n_checked = 0;
  int unsigned n_last = 0;
  int unsigned n_err = 0;
  int unsigned n_cfg = 0;
  int          g_items = 0;
  int          phase = 0;

  function automatic bit dims_valid(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    return w != 0 && h != 0 && w % 8 == 0 && h % 8 == 0 &&
           w <= MAX_WIDTH && h <= MAX_HEIGHT;
  endfunction

  function automatic int stride_of(logic [DIM_W-1:0] w);
    return ((int'(w) + STRIDE_ROUND) / 32) * 4;
  endfunction

  function automatic int load_limit(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    return dims_valid(w, h) ? stride_of(w) * int'(h) : STORE_DEPTH;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic void apply_cfg(logic [CFG_AW-1:0] idx, logic [DIM_W-1:0] val);
    case (idx)
      CFG_WIDTH:  p_w = val;
      CFG_HEIGHT: p_h = val;
      default:    return;
    endcase
    p_ld   = '0;
    p_col  = '0;
    p_band = '0;
  endfunction

  function automatic void load_pixel_byte(logic [7:0] d);
    int lim;
    lim = load_limit(p_w, p_h);
    if (int'(p_ld) >= lim) p_ld = '0;
    p_store[p_ld] = ~d;
    p_ld = p_ld + 1'b1;
    if (int'(p_ld) >= lim) p_ld = '0;
  endfunction

  function automatic col_byte_t next_column_byte();
    col_byte_t r;
    int        bands;
    int        s;
    int        x;
    int        b;
    int        c;
    int        row;
    logic [7:0] v;
    r = '0;
    if (!dims_valid(p_w, p_h)) begin
      r.err = 1'b1;
      return r;
    end
    bands = int'(p_h) / 8;
    s     = stride_of(p_w);
    if (int'(p_col) >= int'(p_w) || int'(p_band) >= bands) begin
      p_col  = '0;
      p_band = '0;
    end
    x = int'(p_col);
    b = int'(p_band);
    for (c = 0; c < 8; c++) begin
      row = int'(p_h) - 1 - 8 * b - c;
      v = p_store[row * s + x / 8];
      r.rot[7 - c] = v[7 - (x % 8)];
    end
    r.last = (x == int'(p_w) - 1) && (b == bands - 1);
    if (b + 1 < bands) begin
      p_band = p_band + 1'b1;
    end else begin
      p_band = '0;
      p_col  = (x + 1 < int'(p_w)) ? p_col + 1'b1 : '0;
    end
    return r;
  endfunction

  // driver and predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
      p_ld      = '0;
      p_col     = '0;
      p_band    = '0;
      p_w       = 9'd8;
      p_h       = 9'd8;
    end else begin
      if (cfg_we) apply_cfg(cfg_addr, cfg_wdata);
      if (in_tvalid && in_tready) begin
        if (in_tuser == ACT_LOAD) begin
          load_pixel_byte(in_tdata);
          n_loads++;
        end else begin
          column_bytes_q.push_back(next_column_byte());
          n_reads++;
        end
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_tvalid <= 1'b0;
          in_gap    <= in_gap - 1;
        end else if (req_q.size() != 0) begin
          drv_req = req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= drv_req.data;
          in_tuser  <= drv_req.act;
          in_gap    <= (in_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and result check
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
      out_hold   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (column_bytes_q.size() == 0) begin
          $error("unexpected result: rotated_byte %h last %b err %b",
                 out_tdata, out_tlast, out_tuser);
          n_fail++;
        end else begin
          want = column_bytes_q.pop_front();
          n_checked++;
          if (want.last) n_last++;
          if (want.err) n_err++;
          if (out_tdata !== want.rot) begin
            $error("rotated_byte: expected %h, actual %h", want.rot, out_tdata);
            n_fail++;
          end
          if (out_tlast !== want.last) begin
            $error("last_byte: expected %b, actual %b", want.last, out_tlast);
            n_fail++;
          end
          if (out_tuser !== want.err) begin
            $error("dims_error: expected %b, actual %b", want.err, out_tuser);
            n_fail++;
          end
        end
      end
      if (out_hold != 0) begin
        out_tready <= 1'b0;
        out_hold   <= out_hold - 1;
      end else if (hold_ask != hold_seen) begin
        hold_seen  <= hold_ask;
        out_hold   <= HOLD_LEN;
        out_tready <= 1'b0;
      end else if (out_gap != 0) begin
        out_tready <= 1'b0;
        out_gap    <= out_gap - 1;
      end else begin
        out_tready <= 1'b1;
        if (out_idle_on && $urandom_range(0, 3) == 0) out_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus
  function automatic bit busy();
    return req_q.size() != 0 || in_tvalid || column_bytes_q.size() != 0;
  endfunction

  function automatic bit can_read();
    int s;
    int r;
    int k;
    if (!dims_valid(g_w, g_h)) return 1'b1;
    s = stride_of(g_w);
    for (r = 0; r < int'(g_h); r++)
      for (k = 0; k < int'(g_w) / 8; k++)
        if (!g_written[r * s + k]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic push_load(logic [7:0] d);
    int   lim;
    req_t r;
    lim = load_limit(g_w, g_h);
    if (int'(g_ld) >= lim) g_ld = '0;
    g_written[g_ld] = 1'b1;
    g_ld = g_ld + 1'b1;
    if (int'(g_ld) >= lim) g_ld = '0;
    r.act  = ACT_LOAD;
    r.data = d;
    req_q.push_back(r);
    g_items++;
  endtask

  task automatic push_reads(int n);
    req_t r;
    repeat (n) begin
      if (can_read()) begin
        r.act  = ACT_READ;
        r.data = 8'($urandom_range(0, 255));
        req_q.push_back(r);
        g_items++;
      end
    end
  endtask

  task automatic load_image();
    if (dims_valid(g_w, g_h))
      repeat (stride_of(g_w) * int'(g_h)) push_load(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (busy());
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_AW-1:0] idx, logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_cfg++;
    if (idx == CFG_WIDTH || idx == CFG_HEIGHT) begin
      if (idx == CFG_WIDTH) g_w = val;
      else g_h = val;
      g_ld = '0;
    end
  endtask

  task automatic set_dims(int w, int h);
    wait_idle();
    cfg_write(CFG_WIDTH, DIM_W'(w));
    cfg_write(CFG_HEIGHT, DIM_W'(h));
  endtask

  task automatic spare_write();
    wait_idle();
    cfg_write($urandom_range(0, 1) ? CFG_SPARE2 : CFG_SPARE3,
              DIM_W'($urandom_range(0, 511)));
  endtask

  task automatic well_formed();
    int w;
    int h;
    int n;
    int k;
    w = 8 * $urandom_range(1, ($urandom_range(0, 3) == 0) ? 8 : 3);
    h = 8 * $urandom_range(1, ($urandom_range(0, 3) == 0) ? 4 : 2);
    set_dims(w, h);
    load_image();
    n = w * h / 8;
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, n);
      push_reads(k);
      spare_write();
      push_reads(n - k);
    end else begin
      push_reads(n + $urandom_range(0, n / 2));
    end
  endtask

  task automatic noise();
    repeat ($urandom_range(20, 60)) begin
      if ($urandom_range(0, 1) == 0) push_load(8'($urandom_range(0, 255)));
      else push_reads(1);
      if ($urandom_range(0, 29) == 0) begin
        // broken image: width rewrite restarts counters; spare write keeps them
        if ($urandom_range(0, 1) == 0) spare_write();
        else begin
          wait_idle();
          cfg_write(CFG_WIDTH, g_w);
        end
      end
    end
  endtask

  task automatic bad_dims();
    int bad;
    int good;
    case ($urandom_range(0, 3))
      0:       bad = 0;
      1:       bad = 8 * $urandom_range(0, 31) + $urandom_range(1, 7);
      2:       bad = 8 * $urandom_range(33, 63);
      default: bad = $urandom_range(0, 1) ? 511 : 257;
    endcase
    good = 8 * $urandom_range(1, 32);
    if ($urandom_range(0, 1) == 0) set_dims(bad, good);
    else set_dims(good, bad);
    repeat ($urandom_range(10, 30)) begin
      if ($urandom_range(0, 1) == 0) push_load(8'($urandom_range(0, 255)));
      else push_reads(1);
    end
  endtask

  // widest image, read out while the receiver holds off
  task automatic big_images();
    set_dims(256, 8);
    in_idle_on = 1'b0;
    load_image();
    hold_ask++;
    push_reads(256 + 8);
  endtask

  initial begin
    g_w = 9'd8;
    g_h = 9'd8;
    g_ld = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // directed: bad width, loads with edge patterns, reset-size image
    cfg_write(CFG_WIDTH, 9'd0);
    push_reads(1);
    push_load(8'h00);
    push_load(8'hff);
    push_load(8'h80);
    push_load(8'h01);
    repeat (28) push_load(8'($urandom_range(0, 255)));
    push_reads(1);
    wait_idle();
    cfg_write(CFG_WIDTH, 9'd8);
    push_reads(3);
    wait_idle();
    cfg_write(CFG_SPARE2, 9'h1ff);
    push_reads(6);
    wait_idle();
    cfg_write(CFG_SPARE3, 9'h000);
    cfg_write(CFG_HEIGHT, 9'h1ff);
    push_reads(1);
    g_items = 0;

    while (g_items < RANDOM_ITEMS) begin
      phase++;
      wait_idle();
      in_idle_on  = ($urandom_range(0, 4) != 0);
      out_idle_on = ($urandom_range(0, 4) != 0);
      if (phase == BIG_PHASE) big_images();
      else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: well_formed();
          6, 7:             noise();
          default:          bad_dims();
        endcase
      end
    end

    wait_idle();
    repeat (SETTLE) @(negedge clk);
    $display("Run covered %0d loads, %0d reads, %0d register writes over %0d phases.",
             n_loads, n_reads, n_cfg, phase);
    $display("Checked %0d column bytes: %0d image ends, %0d bad-dimension replies.",
             n_checked, n_last, n_err);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: mono_bitmap_rotate_to_printer_columns_top.f
+incdir+rtl
rtl/mbr_pkg.sv
rtl/mbr_store.sv
rtl/mbr_col_shift.sv
rtl/mbr_ctrl.sv
rtl/mono_bitmap_rotate_to_printer_columns_top.sv
tb/mono_bitmap_rotate_to_printer_columns_top_tb.sv
